@@ sv/cism_pkg.sv @@
// Shared constants, types and helpers for the case-insensitive substring matcher.
`timescale 1ns / 1ps

package cism_pkg;

    localparam int MAX_CHARS = 63;
    localparam int LEN_W     = $clog2(MAX_CHARS + 1);
    localparam int IDX_W     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] char_byte;
        logic       char_valid;
        logic       last;
    } cism_item_t;

    typedef struct packed {
        logic emit;
        logic found;
    } cism_result_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ sv/cism_core.sv @@
// Pattern store and shift-and match state; updates once per item that steps through.
`timescale 1ns / 1ps

module cism_core
    import cism_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  cism_item_t   item,
    output cism_result_t result
);

    logic [7:0]           store_reg [MAX_CHARS];
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 closed_reg, closed_next;
    logic [MAX_CHARS-1:0] pmv_reg, pmv_next;
    logic [LEN_W-1:0]     tc_reg, tc_next;
    logic                 hit_reg, hit_next;

    logic [7:0]           c;
    logic [LEN_W-1:0]     len_base;
    logic [LEN_W-1:0]     len_m1;
    logic [MAX_CHARS-1:0] eq;
    logic [MAX_CHARS-1:0] pmv_step;
    logic                 hit_step;
    logic                 store_we;
    logic [IDX_W-1:0]     store_addr;

    always_comb
    begin
        c        = fold_case(item.char_byte);
        len_base = closed_reg ? '0 : len_reg;
        len_m1   = len_reg - LEN_W'(1);

        // one comparator per stored pattern byte, masked past the length
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            eq[i] = (LEN_W'(i) < len_reg) && (store_reg[i] == c);
        end
        pmv_step = ((pmv_reg << 1) | MAX_CHARS'(1)) & eq;
        hit_step = (len_reg != '0) && pmv_step[len_m1[IDX_W-1:0]];

        len_next    = len_reg;
        closed_next = closed_reg;
        pmv_next    = pmv_reg;
        tc_next     = tc_reg;
        hit_next    = hit_reg;
        store_we    = 1'b0;
        store_addr  = len_base[IDX_W-1:0];
        result.emit  = 1'b0;
        result.found = 1'b0;

        if (step)
        begin
            case (item.op)
                OP_PATTERN:
                begin
                    len_next = len_base;
                    closed_next = 1'b0;
                    if (closed_reg)
                    begin
                        pmv_next = '0;
                        tc_next  = '0;
                        hit_next = 1'b0;
                    end
                    if (item.char_valid && (len_base < LEN_W'(MAX_CHARS)))
                    begin
                        store_we = 1'b1;
                        len_next = len_base + LEN_W'(1);
                    end
                    if (item.last)
                    begin
                        closed_next = 1'b1;
                        pmv_next    = '0;
                        tc_next     = '0;
                        hit_next    = 1'b0;
                    end
                end
                OP_TEXT:
                begin
                    closed_next = 1'b1;
                    if (item.char_valid && (tc_reg < LEN_W'(MAX_CHARS)))
                    begin
                        pmv_next = pmv_step;
                        hit_next = hit_reg | hit_step;
                        tc_next  = tc_reg + LEN_W'(1);
                    end
                    if (item.last)
                    begin
                        result.emit  = 1'b1;
                        result.found = hit_next || (len_reg == '0);
                        pmv_next     = '0;
                        tc_next      = '0;
                        hit_next     = 1'b0;
                    end
                end
                default:
                begin
                    closed_next = closed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_addr] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            closed_reg <= 1'b0;
            pmv_reg    <= '0;
            tc_reg     <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            closed_reg <= closed_next;
            pmv_reg    <= pmv_next;
            tc_reg     <= tc_next;
            hit_reg    <= hit_next;
        end
    end

endmodule

@@ sv/case_insensitive_substring_match.sv @@
// Top level: input beat register, match core and result register.
//
//  channel | direction | handshake                  | payload
//  item    | in        | item_valid / item_stall     | op, char_byte, char_valid, last
//  result  | out       | result_valid / result_stall | found
//
// One item per cycle unless stalled; each item waits in the input register,
// where the shift-and update runs against all stored pattern bytes in parallel.
// A text-last item passes the input register, then the result register once it is free.
// The input stalls only when a text-last item meets a result that is still held.
// rst_n clears all control state; the pattern store needs no reset.
`timescale 1ns / 1ps

module case_insensitive_substring_match
    import cism_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       op,
    input  logic [7:0] char_byte,
    input  logic       char_valid,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       found
);

    cism_item_t   item_reg;
    logic         busy_reg, busy_next;
    logic         out_valid_reg, out_valid_next;
    logic         found_reg;
    cism_result_t res;
    logic         out_free;
    logic         advance;
    logic         accept;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = busy_reg && (!((item_reg.op == OP_TEXT) && item_reg.last) || out_free);
    assign item_stall = busy_reg && !advance;
    assign accept     = item_valid && !item_stall;

    cism_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (res)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: load on accept, hold result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op         <= op;
            item_reg.char_byte  <= char_byte;
            item_reg.char_valid <= char_valid;
            item_reg.last       <= last;
        end
        if (res.emit)
        begin
            found_reg <= res.found;
        end
    end

    assign result_valid = out_valid_reg;
    assign found        = found_reg;

endmodule

@@ sv/cism_checker.sv @@
// Port-level checks for the substring matcher, bound to the top level.
`timescale 1ns / 1ps

module cism_checker
    import cism_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       op,
    input logic [7:0] char_byte,
    input logic       char_valid,
    input logic       last,
    input logic       result_valid,
    input logic       result_stall,
    input logic       found
);

    // held result stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(found))
        else $error("found changed while stalled");

    // pattern beats never back up the input
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (op == OP_PATTERN) |=> !item_stall)
        else $error("input stalled behind a pattern beat");

    // a text-last beat accepted with no result held shows a result via the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (op == OP_TEXT) && last && !result_valid
        |=> ##1 result_valid)
        else $error("missing result after text-last beat");

endmodule

bind case_insensitive_substring_match cism_checker u_cism_checker (.*);
